FILE: hw/rtl/cpsb_pkg.sv
// ----------------------------------------------------------------------------
// cpsb_pkg: shared types and constants of the column post sprite blitter
// Holds default parameter values, field widths, request codes, register
// indexes and the pixel event passed from the post parser to the top level.
// ----------------------------------------------------------------------------
package cpsb_pkg;

    localparam int MAX_SCALE_DEF   = 8;
    localparam int ADDR_BITS_DEF   = 24;
    localparam int TABLE_DEPTH_DEF = 256;

    localparam int BYTE_W    = 8;
    localparam int COL_W     = 10;
    localparam int SCALE_W   = 4;
    localparam int ROWSUM_W  = BYTE_W + 1;
    localparam int ROW0_W    = ROWSUM_W + SCALE_W;
    localparam int BASE_W    = 24;
    localparam int STRIDE_W  = 12;
    localparam int HEIGHT_W  = 10;
    localparam int OUT_ADDR_W = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [BYTE_W-1:0] END_MARK = 8'hff;

    // Request kinds carried in tuser.
    localparam logic REQ_STREAM = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_STRIDE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPR_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPR_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOLOUR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR      = 3'd6;

    // Parser verdict for the byte accepted in this cycle.
    typedef struct packed {
        logic                emit;    // byte is a pixel to be drawn
        logic [ROWSUM_W-1:0] rowsum;  // post_top + row within the post
    } t_pix_evt;

endpackage

FILE: hw/rtl/cpsb_parser.sv
// ----------------------------------------------------------------------------
// cpsb_parser: column post stream parser
// Walks topdelta, length, pad, pixels, pad for each post of a column and
// flags the bytes that are pixels, together with their row inside the sprite.
// ----------------------------------------------------------------------------
module cpsb_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,   // stream byte accepted
    input  logic                            i_start,
    input  logic [cpsb_pkg::BYTE_W-1:0]     i_byte,
    input  logic [cpsb_pkg::HEIGHT_W-1:0]   i_height,
    output cpsb_pkg::t_pix_evt              o_evt
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_TOP, PH_LEN, PH_PADA, PH_PIX, PH_PADB
    } t_phase;

    t_phase                        r_phase, n_phase;
    logic [cpsb_pkg::BYTE_W-1:0]   r_post_top, n_post_top;
    logic [cpsb_pkg::BYTE_W-1:0]   r_pix_left, n_pix_left;
    logic [cpsb_pkg::BYTE_W-1:0]   r_row, n_row;
    logic [cpsb_pkg::HEIGHT_W-1:0] post_end;

    assign post_end = cpsb_pkg::HEIGHT_W'(r_post_top) + cpsb_pkg::HEIGHT_W'(i_byte);

    always_comb begin
        n_phase    = r_phase;
        n_post_top = r_post_top;
        n_pix_left = r_pix_left;
        n_row      = r_row;
        if (i_accept) begin
            if (i_start || r_phase == PH_TOP) begin
                if (i_byte == cpsb_pkg::END_MARK) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_post_top = i_byte;
                    n_phase    = PH_LEN;
                end
            end else begin
                case (r_phase)
                    PH_LEN: begin
                        // A post running past the declared height kills the column.
                        if (post_end > i_height) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_pix_left = i_byte;
                            n_row      = '0;
                            n_phase    = PH_PADA;
                        end
                    end
                    PH_PADA: n_phase = (r_pix_left == '0) ? PH_PADB : PH_PIX;
                    PH_PIX: begin
                        n_row      = r_row + 1'b1;
                        n_pix_left = r_pix_left - 1'b1;
                        if (r_pix_left == cpsb_pkg::BYTE_W'(1)) begin
                            n_phase = PH_PADB;
                        end
                    end
                    PH_PADB: n_phase = PH_TOP;
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_post_top <= '0;
            r_pix_left <= '0;
            r_row      <= '0;
        end else begin
            r_phase    <= n_phase;
            r_post_top <= n_post_top;
            r_pix_left <= n_pix_left;
            r_row      <= n_row;
        end
    end

    assign o_evt.emit   = i_accept && !i_start && (r_phase == PH_PIX);
    assign o_evt.rowsum = cpsb_pkg::ROWSUM_W'(r_post_top) + cpsb_pkg::ROWSUM_W'(r_row);

endmodule

FILE: hw/rtl/column_post_sprite_blitter_unit.sv
// ----------------------------------------------------------------------------
// column_post_sprite_blitter_unit: scaled column post sprite blitter
// Parses column post bytes, recolors pixels through a loaded table and
// emits each pixel as effective block_scale horizontal row runs in the framebuffer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction
//  s_axis    in         one stream byte or one table load per transaction
//  m_axis    out        one row run: address, pixel value, run length, tlast
//  i_cfg_*   in         one register write per cycle with i_cfg_we high
//
//  A table load or a non-pixel byte leaves the input ready. A pixel byte
//  makes three setup passes through the shared multiply-add unit, then
//  emits effective block_scale runs, one run per cycle while m_axis is not
//  stalled. The input is not ready while a pixel is in progress.
//  Reset is synchronous; the recolor table is not cleared and needs no pass.
// ----------------------------------------------------------------------------
module column_post_sprite_blitter_unit #(
    parameter int MAX_SCALE   = cpsb_pkg::MAX_SCALE_DEF,
    parameter int ADDR_BITS   = cpsb_pkg::ADDR_BITS_DEF,
    parameter int TABLE_DEPTH = cpsb_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // column_number[9:0], stream_byte[17:10], table_slot[25:18], zeros[31:26]
    input  logic [31:0]                         s_axis_tdata,
    // req_type[0], column_start[1]
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // write_address[23:0], pixel_value[31:24], run_length[35:32], zeros[39:36]
    output logic [39:0]                         m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [cpsb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cpsb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int TBL_AW = $clog2(TABLE_DEPTH);
    localparam int PROD_W = ADDR_BITS + cpsb_pkg::ROW0_W;

    typedef enum logic [2:0] {
        S_IDLE, S_ROW, S_BASE, S_ADDR, S_EMIT
    } t_state;

    // Configuration registers.
    logic [cpsb_pkg::BASE_W-1:0]    r_cfg_base;
    logic [cpsb_pkg::STRIDE_W-1:0]  r_cfg_stride;
    logic [cpsb_pkg::SCALE_W-1:0]   r_cfg_scale;
    logic [cpsb_pkg::HEIGHT_W-1:0]  r_cfg_height;
    logic [cpsb_pkg::COL_W-1:0]     r_cfg_width;
    logic                           r_cfg_recolour;
    logic                           r_cfg_mirror;

    // Input fields.
    logic                           in_req;
    logic                           in_start;
    logic [cpsb_pkg::COL_W-1:0]     in_col;
    logic [cpsb_pkg::BYTE_W-1:0]    in_byte;
    logic [cpsb_pkg::BYTE_W-1:0]    in_slot;
    logic                           in_accept;
    cpsb_pkg::t_pix_evt             evt;

    // Datapath.
    t_state                         r_state;
    logic [cpsb_pkg::COL_W-1:0]     r_col;
    logic [cpsb_pkg::BYTE_W-1:0]    r_byte;
    logic [cpsb_pkg::ROWSUM_W-1:0]  r_rowsum;
    logic [cpsb_pkg::ROW0_W-1:0]    r_row0;
    logic [ADDR_BITS-1:0]           r_addr;
    logic [cpsb_pkg::BYTE_W-1:0]    r_pix;
    logic [cpsb_pkg::SCALE_W-1:0]   r_run;
    logic                           r_out_valid;
    logic                           r_out_last;
    logic [cpsb_pkg::BYTE_W-1:0]    r_tbl_q;
    logic [cpsb_pkg::BYTE_W-1:0]    r_table [TABLE_DEPTH];

    logic [cpsb_pkg::SCALE_W-1:0]   eff_scale;
    logic [ADDR_BITS-1:0]           place;
    logic [ADDR_BITS-1:0]           mac_a;
    logic [cpsb_pkg::ROW0_W-1:0]    mac_b;
    logic [ADDR_BITS-1:0]           mac_c;
    logic [PROD_W-1:0]              mac_prod;
    logic [ADDR_BITS-1:0]           mac_y;
    logic                           out_fire;

    assign in_req    = s_axis_tuser[0];
    assign in_start  = s_axis_tuser[1];
    assign in_col    = s_axis_tdata[9:0];
    assign in_byte   = s_axis_tdata[17:10];
    assign in_slot   = s_axis_tdata[25:18];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_fire  = r_out_valid && m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);

    cpsb_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept && in_req == cpsb_pkg::REQ_STREAM),
        .i_start  (in_start),
        .i_byte   (in_byte),
        .i_height (r_cfg_height),
        .o_evt    (evt)
    );

    always_comb begin
        if (r_cfg_scale == '0) begin
            eff_scale = cpsb_pkg::SCALE_W'(1);
        end else if (r_cfg_scale > cpsb_pkg::SCALE_W'(MAX_SCALE)) begin
            eff_scale = cpsb_pkg::SCALE_W'(MAX_SCALE);
        end else begin
            eff_scale = r_cfg_scale;
        end
    end

    // Mirrored placement wraps at the address width like the rest of the math.
    assign place = r_cfg_mirror
                 ? ADDR_BITS'(r_cfg_width) - ADDR_BITS'(1) - ADDR_BITS'(r_col)
                 : ADDR_BITS'(r_col);

    // Shared multiply-add unit: y = c + a * b, modulo 2^ADDR_BITS.
    always_comb begin
        mac_a = ADDR_BITS'(r_cfg_stride);
        mac_b = cpsb_pkg::ROW0_W'(1);
        mac_c = r_addr;
        case (r_state)
            S_ROW: begin
                mac_a = ADDR_BITS'(r_rowsum);
                mac_b = cpsb_pkg::ROW0_W'(eff_scale);
                mac_c = '0;
            end
            S_BASE: begin
                mac_a = place;
                mac_b = cpsb_pkg::ROW0_W'(eff_scale);
                mac_c = ADDR_BITS'(r_cfg_base);
            end
            S_ADDR: begin
                mac_b = r_row0;
            end
            default: begin
                mac_b = cpsb_pkg::ROW0_W'(1);
            end
        endcase
    end

    assign mac_prod = PROD_W'(mac_a) * PROD_W'(mac_b);
    assign mac_y    = mac_c + mac_prod[ADDR_BITS-1:0];

    // Recolor table: one write port for loads, one registered read per accepted stream byte.
    always_ff @(posedge i_clk) begin
        if (in_accept && in_req == cpsb_pkg::REQ_LOAD) begin
            r_table[in_slot[TBL_AW-1:0]] <= in_byte;
        end
        if (in_accept && in_req == cpsb_pkg::REQ_STREAM) begin
            r_tbl_q <= r_table[in_byte[TBL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base     <= '0;
            r_cfg_stride   <= cpsb_pkg::STRIDE_W'(320);
            r_cfg_scale    <= cpsb_pkg::SCALE_W'(1);
            r_cfg_height   <= '0;
            r_cfg_width    <= cpsb_pkg::COL_W'(1);
            r_cfg_recolour <= 1'b0;
            r_cfg_mirror   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cpsb_pkg::CFG_DEST_BASE:   r_cfg_base     <= i_cfg_data[23:0];
                cpsb_pkg::CFG_DEST_STRIDE: r_cfg_stride   <= i_cfg_data[11:0];
                cpsb_pkg::CFG_BLOCK_SCALE: r_cfg_scale    <= i_cfg_data[3:0];
                cpsb_pkg::CFG_SPR_HEIGHT:  r_cfg_height   <= i_cfg_data[9:0];
                cpsb_pkg::CFG_SPR_WIDTH:   r_cfg_width    <= i_cfg_data[9:0];
                cpsb_pkg::CFG_RECOLOUR:    r_cfg_recolour <= i_cfg_data[0];
                cpsb_pkg::CFG_MIRROR:      r_cfg_mirror   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_run       <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (evt.emit) begin
                        r_col    <= in_col;
                        r_byte   <= in_byte;
                        r_rowsum <= evt.rowsum;
                        r_state  <= S_ROW;
                    end
                end
                S_ROW: begin
                    r_row0  <= mac_y[cpsb_pkg::ROW0_W-1:0];
                    r_state <= S_BASE;
                end
                S_BASE: begin
                    r_addr  <= mac_y;
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    r_addr      <= mac_y;
                    r_pix       <= r_cfg_recolour ? r_tbl_q : r_byte;
                    r_run       <= '0;
                    r_out_valid <= 1'b1;
                    r_out_last  <= (eff_scale == cpsb_pkg::SCALE_W'(1));
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_fire) begin
                        if (r_out_last) begin
                            r_out_valid <= 1'b0;
                            r_out_last  <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            // Next row of the square is one stride further down.
                            r_addr     <= mac_y;
                            r_run      <= r_run + 1'b1;
                            r_out_last <= (r_run + cpsb_pkg::SCALE_W'(2) == eff_scale);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {4'b0000, eff_scale, r_pix,
                            cpsb_pkg::OUT_ADDR_W'(r_addr)};

    a_busy_not_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !s_axis_tready)
        else $error("input ready while a run is pending");

    a_last_ends_pixel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && r_out_last) |=> (!r_out_valid && s_axis_tready))
        else $error("block did not return to idle after the last run");

    a_plain_byte_quick : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !evt.emit) |=> s_axis_tready)
        else $error("non-pixel transaction held the input");

    a_run_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_run < eff_scale))
        else $error("run counter past the block scale");

endmodule
